>>> sv/mtep_pkg.sv
// mtep_pkg: types, codes and helper functions of the midi track event parser
// used by the parser, the result register, the top level and the output channel interface
package mtep_pkg;

  localparam int unsigned LEN_BITS_DEF = 32;

  localparam logic [7:0] STATUS_META  = 8'hFF;
  localparam logic [7:0] STATUS_SYSEX = 8'hF0;
  localparam logic [7:0] STATUS_ESC   = 8'hF7;
  localparam logic [7:0] STATUS_RT    = 8'hF8;
  localparam logic [7:0] STATUS_SYS   = 8'hF0;
  localparam logic [6:0] DATA_MASK    = 7'h7F;
  localparam logic [3:0] CMD_PROGRAM  = 4'hC;
  localparam logic [3:0] CMD_CH_PRESS = 4'hD;

  typedef enum logic [2:0] {
    PH_WAIT  = 3'd0,
    PH_CHAN  = 3'd1,
    PH_MTYPE = 3'd2,
    PH_MLEN  = 3'd3,
    PH_MDATA = 3'd4,
    PH_SLEN  = 3'd5,
    PH_SDATA = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    EV_CHANNEL  = 3'd0,
    EV_REALTIME = 3'd1,
    EV_META     = 3'd2,
    EV_SYSEX_F0 = 3'd3,
    EV_SYSEX_F7 = 3'd4,
    EV_ERROR    = 3'd5
  } event_kind_e;

  typedef struct packed {
    event_kind_e event_kind;
    logic [7:0]  status_byte;
    logic [3:0]  channel;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [1:0]  data_count;
    logic [7:0]  meta_kind;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        last;
    logic        used_running;
  } result_t;

  function automatic logic needs_two(input logic [7:0] status);
    logic [3:0] cmd;
    cmd = status[7:4];
    return !(cmd == CMD_PROGRAM || cmd == CMD_CH_PRESS);
  endfunction

  function automatic event_kind_e sysex_kind(input logic [7:0] status);
    return (status == STATUS_SYSEX) ? EV_SYSEX_F0 : EV_SYSEX_F7;
  endfunction

endpackage

>>> sv/mtep_if.sv
// mtep_in_if / mtep_out_if: valid-ready channels of the parser
// depends on mtep_pkg for the result kind type
interface mtep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface mtep_out_if
  import mtep_pkg::*;
;
  logic        valid;
  logic        ready;
  event_kind_e event_kind;
  logic [7:0]  status_byte;
  logic [3:0]  channel;
  logic [7:0]  first_data;
  logic [7:0]  second_data;
  logic [1:0]  data_count;
  logic [7:0]  meta_kind;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic        last;
  logic        used_running;

  modport source (
    output valid, output event_kind, output status_byte, output channel,
    output first_data, output second_data, output data_count, output meta_kind,
    output payload_byte, output payload_valid, output last, output used_running,
    input ready
  );
  modport sink (
    input valid, input event_kind, input status_byte, input channel,
    input first_data, input second_data, input data_count, input meta_kind,
    input payload_byte, input payload_valid, input last, input used_running,
    output ready
  );
endinterface

>>> sv/mtep_in_reg.sv
// mtep_in_reg: input byte register in front of the parser
// depends on nothing but the clock and reset
module mtep_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] byte_i,
  output logic       ready_o,
  input  logic       advance_i,
  output logic       full_o,
  output logic [7:0] byte_o
);

  logic       full_q, full_d;
  logic [7:0] byte_q;

  assign ready_o = !full_q || advance_i;
  assign full_d  = (valid_i && ready_o) || (full_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      byte_q <= byte_i;
    end
  end

  assign full_o = full_q;
  assign byte_o = byte_q;

endmodule

>>> sv/mtep_parser.sv
// mtep_parser: parse state and one-byte step of the track event parser
// depends on mtep_pkg for phases, codes and the result struct
module mtep_parser
  import mtep_pkg::*;
#(
  parameter int unsigned LEN_BITS = LEN_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  phase_e                phase_q, phase_d;
  logic [7:0]            run_status_q, run_status_d;
  logic [7:0]            cur_status_q, cur_status_d;
  logic [7:0]            meta_type_q, meta_type_d;
  logic [LEN_BITS-1:0]   len_q, len_d;
  logic [LEN_BITS-1:0]   cnt_q, cnt_d;
  logic                  need_two_q, need_two_d;
  logic                  seen_q, seen_d;
  logic [7:0]            held_q, held_d;
  logic                  run_flag_q, run_flag_d;

  logic [LEN_BITS-1:0]   len_new;
  logic [LEN_BITS-1:0]   cnt_inc;
  logic                  fin;

  assign len_new = {len_q[LEN_BITS-8:0], byte_i[6:0] & DATA_MASK};
  assign cnt_inc = cnt_q + LEN_BITS'(1);
  assign fin     = (cnt_inc >= len_q);

  always_comb begin
    phase_d      = phase_q;
    run_status_d = run_status_q;
    cur_status_d = cur_status_q;
    meta_type_d  = meta_type_q;
    len_d        = len_q;
    cnt_d        = cnt_q;
    need_two_d   = need_two_q;
    seen_d       = seen_q;
    held_d       = held_q;
    run_flag_d   = run_flag_q;
    res_valid_o  = 1'b0;
    res_o        = '0;
    res_o.last   = 1'b1;

    case (phase_q)
      PH_WAIT: begin
        if (byte_i[7]) begin
          if (byte_i == STATUS_META) begin
            cur_status_d = byte_i;
            run_status_d = '0;
            phase_d      = PH_MTYPE;
          end else if (byte_i == STATUS_SYSEX || byte_i == STATUS_ESC) begin
            cur_status_d = byte_i;
            run_status_d = '0;
            len_d        = '0;
            phase_d      = PH_SLEN;
          end else if (byte_i >= STATUS_RT) begin
            res_valid_o       = 1'b1;
            res_o.event_kind  = EV_REALTIME;
            res_o.status_byte = byte_i;
            res_o.channel     = byte_i[3:0];
          end else if (byte_i >= STATUS_SYS) begin
            run_status_d = '0;
          end else begin
            cur_status_d = byte_i;
            run_status_d = byte_i;
            need_two_d   = needs_two(byte_i);
            seen_d       = 1'b0;
            run_flag_d   = 1'b0;
            phase_d      = PH_CHAN;
          end
        end else if (run_status_q == '0) begin
          res_valid_o      = 1'b1;
          res_o.event_kind = EV_ERROR;
          res_o.first_data = byte_i;
        end else begin
          cur_status_d = run_status_q;
          need_two_d   = needs_two(run_status_q);
          run_flag_d   = 1'b1;
          if (!needs_two(run_status_q)) begin
            res_valid_o        = 1'b1;
            res_o.event_kind   = EV_CHANNEL;
            res_o.status_byte  = run_status_q;
            res_o.channel      = run_status_q[3:0];
            res_o.first_data   = byte_i;
            res_o.data_count   = 2'd1;
            res_o.used_running = 1'b1;
          end else begin
            held_d  = byte_i;
            seen_d  = 1'b1;
            phase_d = PH_CHAN;
          end
        end
      end
      PH_CHAN: begin
        if (!seen_q && need_two_q) begin
          held_d = byte_i;
          seen_d = 1'b1;
        end else begin
          phase_d            = PH_WAIT;
          seen_d             = 1'b0;
          res_valid_o        = 1'b1;
          res_o.event_kind   = EV_CHANNEL;
          res_o.status_byte  = cur_status_q;
          res_o.channel      = cur_status_q[3:0];
          res_o.used_running = run_flag_q;
          if (!seen_q) begin
            res_o.first_data = byte_i;
            res_o.data_count = 2'd1;
          end else begin
            res_o.first_data  = held_q;
            res_o.second_data = byte_i;
            res_o.data_count  = 2'd2;
          end
        end
      end
      PH_MTYPE: begin
        meta_type_d = byte_i;
        len_d       = '0;
        phase_d     = PH_MLEN;
      end
      PH_MLEN, PH_SLEN: begin
        len_d = len_new;
        if (!byte_i[7]) begin
          cnt_d = '0;
          if (len_new == '0) begin
            phase_d           = PH_WAIT;
            res_valid_o       = 1'b1;
            res_o.status_byte = cur_status_q;
            res_o.channel     = cur_status_q[3:0];
            if (cur_status_q == STATUS_META) begin
              res_o.event_kind = EV_META;
              res_o.meta_kind  = meta_type_q;
            end else begin
              res_o.event_kind = sysex_kind(cur_status_q);
            end
          end else begin
            phase_d = (phase_q == PH_MLEN) ? PH_MDATA : PH_SDATA;
          end
        end
      end
      PH_MDATA, PH_SDATA: begin
        res_valid_o         = 1'b1;
        res_o.status_byte   = cur_status_q;
        res_o.channel       = cur_status_q[3:0];
        res_o.payload_byte  = byte_i;
        res_o.payload_valid = 1'b1;
        res_o.last          = fin;
        if (phase_q == PH_MDATA) begin
          res_o.event_kind = EV_META;
          res_o.meta_kind  = meta_type_q;
        end else begin
          res_o.event_kind = sysex_kind(cur_status_q);
        end
        if (fin) begin
          phase_d = PH_WAIT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      default: begin
        phase_d = PH_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_WAIT;
      run_status_q <= '0;
      cur_status_q <= '0;
      meta_type_q  <= '0;
      len_q        <= '0;
      cnt_q        <= '0;
      need_two_q   <= 1'b0;
      seen_q       <= 1'b0;
      held_q       <= '0;
      run_flag_q   <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      run_status_q <= run_status_d;
      cur_status_q <= cur_status_d;
      meta_type_q  <= meta_type_d;
      len_q        <= len_d;
      cnt_q        <= cnt_d;
      need_two_q   <= need_two_d;
      seen_q       <= seen_d;
      held_q       <= held_d;
      run_flag_q   <= run_flag_d;
    end
  end

endmodule

>>> sv/mtep_out_reg.sv
// mtep_out_reg: result register between the parser and the output channel
// depends on mtep_pkg for the result struct
module mtep_out_reg
  import mtep_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    ready_i,
  output logic    free_o,
  output logic    valid_o,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> sv/midi_track_event_parser_unit.sv
// midi_track_event_parser_unit: top level of the midi track event parser
// path: a byte is held in the input register, its result in the result register, which offers it
// throughput: one byte per cycle while the result register is free, set by the
// single-step parse logic between the input register and the result register
// reset: parser state and both valid flags clear, parser waits for a status
// depends on mtep_pkg, mtep_if, mtep_in_reg, mtep_parser, mtep_out_reg
module midi_track_event_parser_unit
  import mtep_pkg::*;
#(
  parameter int unsigned LEN_BITS = LEN_BITS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  mtep_in_if.sink    in_i,
  mtep_out_if.source out_o
);

  logic       stage_full;
  logic [7:0] stage_byte;
  logic       advance;
  logic       out_free;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  assign advance = stage_full && out_free;

  mtep_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_i.valid),
    .byte_i    (in_i.in_byte),
    .ready_o   (in_i.ready),
    .advance_i (advance),
    .full_o    (stage_full),
    .byte_o    (stage_byte)
  );

  mtep_parser #(
    .LEN_BITS (LEN_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (stage_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mtep_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && res_valid),
    .res_i   (res),
    .ready_i (out_o.ready),
    .free_o  (out_free),
    .valid_o (out_o.valid),
    .res_o   (out_res)
  );

  assign out_o.event_kind    = out_res.event_kind;
  assign out_o.status_byte   = out_res.status_byte;
  assign out_o.channel       = out_res.channel;
  assign out_o.first_data    = out_res.first_data;
  assign out_o.second_data   = out_res.second_data;
  assign out_o.data_count    = out_res.data_count;
  assign out_o.meta_kind     = out_res.meta_kind;
  assign out_o.payload_byte  = out_res.payload_byte;
  assign out_o.payload_valid = out_res.payload_valid;
  assign out_o.last          = out_res.last;
  assign out_o.used_running  = out_res.used_running;

endmodule
